### sv/spmv_pkg.sv
// shared types, constants and floating-point helper functions for the
// csr row-accumulate block; no dependencies
`default_nettype none

package spmv_pkg;

  // vector store geometry
  localparam int VEC_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(VEC_DEPTH);
  localparam int COL_W     = (ADDR_W > 13) ? ADDR_W + 1 : 14;

  // request queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // request function codes
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_NZ   = 2'd1;
  localparam logic [1:0] FN_END  = 2'd2;

  // double-precision bit patterns
  localparam logic [63:0] INF_BITS    = 64'h7FF0000000000000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008000000000000;
  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;
  localparam logic [63:0] ONE_BITS    = 64'h3FF0000000000000;

  typedef logic signed [13:0] exp_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] index;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_sum;
    logic        bad_index;
  } out_item_t;

  // queued operation: a * b + accumulator
  typedef struct packed {
    logic        last;
    logic        bad;
    logic [63:0] a;
    logic [63:0] b;
  } op_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CHK, B_MUL, B_NORM1, B_NORM2, B_ALIGN, B_ADD, B_NORM3, B_SHIFT, B_ROUND
  } back_state_t;

  function automatic logic f_is_nan(input logic [63:0] x);
    return x[62:0] > INF_BITS[62:0];
  endfunction

  function automatic logic f_is_inf(input logic [63:0] x);
    return x[62:0] == INF_BITS[62:0];
  endfunction

  function automatic logic f_is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  // significand with hidden bit
  function automatic logic [52:0] f_sig(input logic [63:0] x);
    return {(x[62:52] != 11'd0), x[51:0]};
  endfunction

  // exponent of the significand's lsb
  function automatic exp_t f_exp(input logic [63:0] x);
    exp_t e;
    if (x[62:52] == 11'd0) begin
      e = -14'sd1074;
    end else begin
      e = $signed({3'b000, x[62:52]}) - 14'sd1075;
    end
    return e;
  endfunction

  // leading zero count, 128 when all zero
  function automatic logic [7:0] lzc128(input logic [127:0] x);
    logic [7:0] z;
    z = 8'd128;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) z = 8'(127 - i);
    end
    return z;
  endfunction

  // right shift with lost bits ored into bit 0
  function automatic logic [127:0] jam128(input logic [127:0] x, input logic [13:0] n);
    logic [127:0] r;
    logic [127:0] mask;
    if (n >= 14'd128) begin
      r = {127'd0, |x};
    end else begin
      mask = ~({128{1'b1}} << n[6:0]);
      r = x >> n[6:0];
      r[0] = r[0] | (|(x & mask));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/csr_spmv_row_accumulate.sv
// top level of the csr row-accumulate block: front end, request queue, back end
// depends on spmv_pkg, spmv_front, spmv_queue, spmv_back
//
//   channel   handshake             payload
//   request   req_valid/req_stall   req: func, index, value
//   result    rsp_valid/rsp_stall   rsp: row_sum, bad_index
//   config    cfg_wen               cfg_wdata: index_base
//
// a load is written to the vector store at the front; a nonzero or end of
// row passes through the vector store lookup and then the back end
// (pop, operand check, four passes of the shared 32x32 multiplier, then
// normalize, align, add, shift and round steps of the single fused
// multiply-add, serialized by the accumulator); special operands finish
// after the operand check and a zero accumulator skips the add step.
// a bad column only sets the row flag when it is popped from the queue.
// reset (rst, synchronous) clears the queue, accumulator, row flag, config.
// the front stalls when the four-entry queue plus the lookup stage would
// hold four requests; a held result blocks only the next end of row.
`default_nettype none

module csr_spmv_row_accumulate (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire spmv_pkg::in_item_t   req,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  output spmv_pkg::out_item_t       rsp,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  input  wire logic                 cfg_wen,
  input  wire logic                 cfg_wdata
);
  import spmv_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  op_t     q_data;
  logic    q_pop;
  op_t     q_head;

  // request front end
  spmv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // request queue
  spmv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // arithmetic back end
  spmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (q_head),
    .q_pop     (q_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_stat.full || q_pop))
    else $error("request queue overflow");

  // queue never underflows
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("request queue underflow");

  // a full queue holds off new requests
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> req_stall)
    else $error("request accepted with full queue");

endmodule

`default_nettype wire

### sv/spmv_queue.sv
// small request queue between the front and the arithmetic back end
// depends on spmv_pkg
`default_nettype none

module spmv_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire spmv_pkg::op_t    push_data,
  input  wire logic             pop,
  output spmv_pkg::op_t         head,
  output spmv_pkg::q_stat_t     stat
);
  import spmv_pkg::*;

  op_t               ents [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'((wr_ptr + 1'b1) % QDEPTH);
      if (pop) rd_ptr <= QPTR_W'((rd_ptr + 1'b1) % QDEPTH);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ents[wr_ptr] <= push_data;
  end

  assign head       = ents[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

### sv/spmv_front.sv
// request front end: config register, vector store, column check, queue feed
// depends on spmv_pkg
`default_nettype none

module spmv_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spmv_pkg::in_item_t  req,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                cfg_wen,
  input  wire logic                cfg_wdata,
  input  wire spmv_pkg::q_stat_t   q_stat,
  output logic                     q_push,
  output spmv_pkg::op_t            q_data
);
  import spmv_pkg::*;

  localparam int SW = QCNT_W + 1;

  logic             index_base;
  logic [63:0]      mem [VEC_DEPTH];
  logic [63:0]      rd_data;
  logic             s1_valid;
  logic             s1_last;
  logic             s1_bad;
  logic [63:0]      s1_value;
  logic             accept;
  logic [COL_W-1:0] ld_addr;
  logic [COL_W-1:0] col;
  logic             ld_ok;
  logic             col_ok;

  // hold off when the queue could not take what is in flight
  assign req_stall = ({1'b0, q_stat.count} + SW'(s1_valid)) >= SW'(QDEPTH);
  assign accept    = req_valid & ~req_stall;

  // address checks
  assign ld_addr = COL_W'(req.index);
  assign col     = COL_W'(req.index) - COL_W'(index_base);
  assign ld_ok   = ld_addr < COL_W'(VEC_DEPTH);
  assign col_ok  = (req.index >= 13'(index_base)) && (col < COL_W'(VEC_DEPTH));

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_base <= 1'b0;
    end else if (cfg_wen) begin
      index_base <= cfg_wdata;
    end
  end

  // vector store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && req.func == FN_LOAD && ld_ok) mem[ld_addr[ADDR_W-1:0]] <= req.value;
    if (accept && req.func == FN_NZ) rd_data <= mem[col[ADDR_W-1:0]];
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (req.func == FN_NZ || req.func == FN_END);
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last  <= (req.func == FN_END);
      s1_bad   <= (req.func == FN_NZ) && !col_ok;
      s1_value <= req.value;
    end
  end

  // queue feed
  assign q_push      = s1_valid;
  assign q_data.last = s1_last;
  assign q_data.bad  = s1_bad;
  assign q_data.a    = s1_value;
  assign q_data.b    = s1_last ? ONE_BITS : rd_data;

endmodule

`default_nettype wire

### sv/spmv_back.sv
// back end: sequential fused multiply-add into the row accumulator,
// row error flag and result register; depends on spmv_pkg
`default_nettype none

module spmv_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spmv_pkg::q_stat_t   q_stat,
  input  wire spmv_pkg::op_t       head,
  output logic                     q_pop,
  output spmv_pkg::out_item_t      rsp,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall
);
  import spmv_pkg::*;

  back_state_t  state;
  back_state_t  state_next;
  logic [63:0]  acc;
  logic         row_error;
  logic         out_valid;
  out_item_t    out_item;

  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [63:0]  op_c;
  logic         op_last;
  logic [52:0]  ma;
  logic [52:0]  mb;
  logic [52:0]  mc;
  exp_t         ea;
  exp_t         eb;
  exp_t         ec;
  logic         czero;
  logic         sp;
  logic         sc;
  logic [127:0] prod;
  logic [1:0]   cnt;
  logic [7:0]   lzp;
  logic [7:0]   lzq;
  logic [127:0] p;
  logic [127:0] q;
  exp_t         ep;
  exp_t         ec2;
  logic [127:0] r;
  exp_t         e;
  logic         sgn;
  exp_t         shf;
  logic         ovf;
  logic [10:0]  field;
  logic [63:0]  t;

  logic         commit;
  logic [63:0]  res;
  logic         special;
  logic [63:0]  spec_val;
  logic [31:0]  mx;
  logic [31:0]  my;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] add_r;
  logic         add_sign;
  exp_t         d;
  logic [127:0] al_p;
  logic [127:0] al_q;
  exp_t         al_e;
  exp_t         kp;
  exp_t         kq;
  logic [7:0]   lzr;
  exp_t         mt;
  exp_t         big;
  exp_t         sh;
  exp_t         low;
  logic         subn;
  exp_t         lsh;
  logic [127:0] jam_r;
  logic [127:0] shl_r;
  logic [63:0]  t_val;
  logic [63:0]  mant;
  logic [63:0]  mant_r;
  logic [63:0]  rnd_val;

  // special operands: nan, infinity, zero products
  always_comb begin
    special  = 1'b1;
    spec_val = 64'd0;
    priority if (f_is_nan(op_a)) begin
      spec_val = op_a | QUIET_BIT;
    end else if (f_is_nan(op_b)) begin
      spec_val = op_b | QUIET_BIT;
    end else if (f_is_nan(op_c)) begin
      spec_val = op_c | QUIET_BIT;
    end else if ((f_is_inf(op_a) && f_is_zero(op_b)) || (f_is_zero(op_a) && f_is_inf(op_b))) begin
      spec_val = DEFAULT_NAN;
    end else if (f_is_inf(op_a) || f_is_inf(op_b)) begin
      spec_val = (f_is_inf(op_c) && sc != sp) ? DEFAULT_NAN : ({sp, 63'd0} | INF_BITS);
    end else if (f_is_inf(op_c)) begin
      spec_val = op_c;
    end else if (f_is_zero(op_a) || f_is_zero(op_b)) begin
      spec_val = f_is_zero(op_c) ? {sp & sc, 63'd0} : op_c;
    end else begin
      special = 1'b0;
    end
  end

  // one 32x32 partial product per pass
  assign mx    = cnt[0] ? {11'd0, ma[52:32]} : ma[31:0];
  assign my    = cnt[1] ? {11'd0, mb[52:32]} : mb[31:0];
  assign pp    = mx * my;
  assign pp_sh = {64'd0, pp} << (7'(cnt[0]) + 7'(cnt[1])) * 7'd32;

  // normalize shift amounts to put the top bit at 125
  assign kp = $signed({6'd0, lzp}) - 14'sd2;
  assign kq = $signed({6'd0, lzq}) - 14'sd2;

  // alignment of the smaller addend
  assign d = ep - ec2;
  always_comb begin
    al_p = p;
    al_q = q;
    al_e = ep;
    if (d >= 14'sd0) begin
      al_q = jam128(q, d);
    end else begin
      al_p = jam128(p, 14'(-d));
      al_e = ec2;
    end
  end

  // signed-magnitude add
  always_comb begin
    if (sp == sc) begin
      add_r    = p + q;
      add_sign = sp;
    end else if (p >= q) begin
      add_r    = p - q;
      add_sign = sp;
    end else begin
      add_r    = q - p;
      add_sign = sc;
    end
  end

  // result exponent and rounding position
  assign lzr  = lzc128(r);
  assign mt   = 14'sd127 - $signed({6'd0, lzr});
  assign big  = mt + e;
  assign sh   = mt - 14'sd52;
  assign low  = -14'sd1074 - e;
  assign subn = low > sh;

  // keep two guard bits, sticky in bit 0
  assign lsh   = 14'sd2 - shf;
  assign jam_r = jam128(r, 14'(shf - 14'sd2));
  assign shl_r = r << lsh[6:0];
  always_comb begin
    if (shf >= 14'sd2) begin
      t_val = jam_r[63:0];
    end else begin
      t_val = shl_r[63:0];
    end
  end

  // round to nearest even and pack
  assign mant    = {2'b00, t[63:2]};
  assign mant_r  = mant + 64'(t[1] & (t[0] | mant[0]));
  assign rnd_val = ovf ? ({sgn, 63'd0} | INF_BITS)
                       : ({sgn, 63'd0} | ({1'b0, field, 52'd0} + mant_r));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, pop and commit
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    commit     = 1'b0;
    res        = rnd_val;
    unique case (state)
      B_IDLE: begin
        if (!q_stat.empty && (!head.last || !out_valid)) begin
          q_pop = 1'b1;
          if (head.last || !head.bad) state_next = B_CHK;
        end
      end
      B_CHK: begin
        if (special) begin
          commit     = 1'b1;
          res        = spec_val;
          state_next = B_IDLE;
        end else begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        if (cnt == 2'd3) state_next = B_NORM1;
      end
      B_NORM1: state_next = B_NORM2;
      B_NORM2: state_next = B_ALIGN;
      B_ALIGN: state_next = czero ? B_NORM3 : B_ADD;
      B_ADD: begin
        if (add_r == 128'd0) begin
          commit     = 1'b1;
          res        = 64'd0;
          state_next = B_IDLE;
        end else begin
          state_next = B_NORM3;
        end
      end
      B_NORM3: state_next = B_SHIFT;
      B_SHIFT: state_next = B_ROUND;
      B_ROUND: begin
        commit     = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // accumulator, row error and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 64'd0;
      row_error <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !rsp_stall) out_valid <= 1'b0;
      if (q_pop && !head.last && head.bad) row_error <= 1'b1;
      if (commit) begin
        if (op_last) begin
          out_valid <= 1'b1;
          acc       <= 64'd0;
          row_error <= 1'b0;
        end else begin
          acc <= res;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (commit && op_last) begin
      out_item.row_sum   <= res;
      out_item.bad_index <= row_error;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        op_a    <= head.a;
        op_b    <= head.b;
        op_c    <= acc;
        op_last <= head.last;
        sp      <= head.a[63] ^ head.b[63];
        sc      <= acc[63];
      end
      B_CHK: begin
        ma    <= f_sig(op_a);
        mb    <= f_sig(op_b);
        mc    <= f_sig(op_c);
        ea    <= f_exp(op_a);
        eb    <= f_exp(op_b);
        ec    <= f_exp(op_c);
        czero <= f_is_zero(op_c);
        prod  <= 128'd0;
        cnt   <= 2'd0;
      end
      B_MUL: begin
        prod <= prod + pp_sh;
        cnt  <= cnt + 2'd1;
      end
      B_NORM1: begin
        lzp <= lzc128(prod);
        lzq <= lzc128({75'd0, mc});
      end
      B_NORM2: begin
        p   <= prod << kp[6:0];
        ep  <= ea + eb - kp;
        q   <= {75'd0, mc} << kq[6:0];
        ec2 <= ec - kq;
      end
      B_ALIGN: begin
        if (czero) begin
          r   <= p;
          e   <= ep;
          sgn <= sp;
        end else begin
          p <= al_p;
          q <= al_q;
          e <= al_e;
        end
      end
      B_ADD: begin
        r   <= add_r;
        sgn <= add_sign;
      end
      B_NORM3: begin
        shf   <= subn ? low : sh;
        ovf   <= big > 14'sd1023;
        field <= subn ? 11'd0 : 11'(big + 14'sd1022);
      end
      B_SHIFT: begin
        t <= t_val;
      end
      B_ROUND: begin
        t <= t;
      end
      default: begin
        t <= t;
      end
    endcase
  end

  assign rsp       = out_item;
  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for csr_spmv_row_accumulate: drives loads, nonzeros and
// row ends, predicts each row sum with a bit-exact double fma, checks every response
// depends on spmv_pkg and the csr_spmv_row_accumulate rtl
`default_nettype none

module testbench;
  import spmv_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 4096;
  localparam int IDLE_PCT    = 17;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  req = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  out_item_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  logic      cfg_wen = 1'b0;
  logic      cfg_wdata = 1'b0;

  // predictor state
  logic [63:0] vec_copy [STORE_DEPTH];
  bit          vec_written [STORE_DEPTH];
  int          loaded_addrs [$];
  logic [63:0] acc_copy = '0;
  logic        row_bad = 1'b0;
  logic        base_copy = 1'b0;
  out_item_t   row_sums [$];

  int  errors = 0;
  int  quiet_cycles = 0;
  int  items_sent = 0;
  bit  idling_on = 1'b1;

  csr_spmv_row_accumulate dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // double classification and arithmetic on bit patterns
  function automatic bit dbl_nan(input logic [63:0] x);
    return x[62:0] > 63'h7FF0000000000000;
  endfunction

  function automatic bit dbl_inf(input logic [63:0] x);
    return x[62:0] == 63'h7FF0000000000000;
  endfunction

  function automatic bit dbl_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic [52:0] split_sig(input logic [63:0] x, output int e);
    if (x[62:52] == 11'd0) begin
      e = -1074;
      return {1'b0, x[51:0]};
    end
    e = int'(x[62:52]) - 1075;
    return {1'b1, x[51:0]};
  endfunction

  function automatic int msb_pos(input logic [127:0] x);
    for (int i = 127; i >= 0; i--) begin
      if (x[i]) return i;
    end
    return -1;
  endfunction

  // right shift keeping a sticky bit
  function automatic logic [127:0] shr_sticky(input logic [127:0] x, input int n);
    logic [127:0] r;
    if (n <= 0) return x;
    if (n >= 128) return {127'd0, |x};
    r = x >> n;
    r[0] = r[0] | (|(x & ((128'd1 << n) - 128'd1)));
    return r;
  endfunction

  // a*b + c with a single round to nearest even
  function automatic logic [63:0] fma_rne(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] c);
    logic sp, sc, sgn, subn;
    int ea, eb, ec, ep, e, k, m, big, low, sh;
    logic [52:0] ma, mb, mc;
    logic [127:0] p, q, r, w;
    logic [63:0] t, mant, field;
    sp = a[63] ^ b[63];
    sc = c[63];
    if (dbl_nan(a)) return a | QUIET_BIT;
    if (dbl_nan(b)) return b | QUIET_BIT;
    if (dbl_nan(c)) return c | QUIET_BIT;
    if ((dbl_inf(a) && dbl_zero(b)) || (dbl_zero(a) && dbl_inf(b))) return DEFAULT_NAN;
    if (dbl_inf(a) || dbl_inf(b)) begin
      if (dbl_inf(c) && sc != sp) return DEFAULT_NAN;
      return {sp, 63'd0} | INF_BITS;
    end
    if (dbl_inf(c)) return c;
    if (dbl_zero(a) || dbl_zero(b)) begin
      if (dbl_zero(c)) return {sp & sc, 63'd0};
      return c;
    end
    ma = split_sig(a, ea);
    mb = split_sig(b, eb);
    p = 128'(ma) * 128'(mb);
    k = 125 - msb_pos(p);
    p = p << k;
    ep = ea + eb - k;
    if (dbl_zero(c)) begin
      r = p;
      e = ep;
      sgn = sp;
    end else begin
      mc = split_sig(c, ec);
      q = 128'(mc);
      k = 125 - msb_pos(q);
      q = q << k;
      ec = ec - k;
      if (ep >= ec) begin
        q = shr_sticky(q, ep - ec);
        e = ep;
      end else begin
        p = shr_sticky(p, ec - ep);
        e = ec;
      end
      if (sp == sc) begin
        r = p + q;
        sgn = sp;
      end else if (p >= q) begin
        r = p - q;
        sgn = sp;
      end else begin
        r = q - p;
        sgn = sc;
      end
      if (r == 128'd0) return 64'd0;
    end
    m = msb_pos(r);
    big = m + e;
    if (big > 1023) return {sgn, 63'd0} | INF_BITS;
    sh = m - 52;
    low = -1074 - e;
    subn = low > sh;
    if (subn) sh = low;
    if (sh >= 2) w = shr_sticky(r, sh - 2);
    else w = r << (2 - sh);
    t = w[63:0];
    mant = t >> 2;
    if (t[1] && (t[0] || mant[0])) mant = mant + 64'd1;
    field = subn ? 64'd0 : 64'(big + 1022);
    return {sgn, 63'd0} | ((field << 52) + mant);
  endfunction

  // fold one accepted request into the predicted state
  task automatic apply_request(input in_item_t it);
    out_item_t o;
    int col;
    case (it.func)
      FN_LOAD: begin
        if (it.index < STORE_DEPTH) begin
          vec_copy[it.index] = it.value;
          if (!vec_written[it.index]) loaded_addrs.push_back(it.index);
          vec_written[it.index] = 1'b1;
        end
      end
      FN_NZ: begin
        col = int'(it.index) - int'(base_copy);
        if (col >= 0 && col < STORE_DEPTH) acc_copy = fma_rne(it.value, vec_copy[col], acc_copy);
        else row_bad = 1'b1;
      end
      FN_END: begin
        o.row_sum = fma_rne(it.value, ONE_BITS, acc_copy);
        o.bad_index = row_bad;
        row_sums.push_back(o);
        acc_copy = '0;
        row_bad = 1'b0;
      end
      default: ;
    endcase
  endtask

  // present one request and wait until it is taken
  task automatic send_req(input logic [1:0] fn, input int idx, input logic [63:0] val);
    in_item_t it;
    it.func = fn;
    it.index = 13'(idx);
    it.value = val;
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_request(it);
    items_sent++;
  endtask

  // stop sending and let every pending row sum come back
  task automatic drain_rows;
    req_valid <= 1'b0;
    while (row_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_base(input logic b);
    drain_rows();
    cfg_wen <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_wen <= 1'b0;
    base_copy = b;
  endtask

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // mixed-class doubles, mostly moderate normals so sums stay meaningful
  function automatic logic [63:0] rand_double;
    logic [63:0] rnd;
    int sel;
    rnd = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 60) return {rnd[63], 11'(993 + $urandom_range(60)), rnd[51:0]};
    if (sel < 70) return rnd;
    if (sel < 75) return {rnd[63], 11'd0, rnd[51:0]};
    if (sel < 80) return {rnd[63], 11'(2040 + $urandom_range(6)), rnd[51:0]};
    if (sel < 84) return {rnd[63], 63'd0};
    if (sel < 87) return {rnd[63], 63'd0} | INF_BITS;
    if (sel < 89) return {rnd[63], 11'h7FF, rnd[51:1], 1'b1};
    case ($urandom_range(3))
      0: return {rnd[63], 63'h7FEFFFFFFFFFFFFF};
      1: return {rnd[63], 63'h0010000000000000};
      2: return {rnd[63], 63'd1};
      default: return {rnd[63], 63'd0} | ONE_BITS;
    endcase
  endfunction

  function automatic int pick_column;
    if ($urandom_range(99) < 92 && loaded_addrs.size() != 0)
      return loaded_addrs[$urandom_range(loaded_addrs.size() - 1)] + int'(base_copy);
    if (base_copy && $urandom_range(1)) return 0;
    return STORE_DEPTH + int'(base_copy) + $urandom_range(8191 - STORE_DEPTH - int'(base_copy));
  endfunction

  // extremes, invalid operations, nan ordering, bad columns, ignored requests
  task automatic test_special_values;
    write_base(1'b0);
    send_req(FN_LOAD, 0, ONE_BITS);
    send_req(FN_LOAD, 1, 64'h7FEFFFFFFFFFFFFF);
    send_req(FN_LOAD, 2, 64'h0000000000000001);
    send_req(FN_LOAD, 3, 64'hFFF0000000000000);
    send_req(FN_LOAD, 4095, 64'h8000000000000000);
    send_req(FN_LOAD, 4096, 64'h4000000000000000);
    send_req(FN_LOAD, 8191, 64'h4000000000000000);
    // overflow to infinity
    send_req(FN_NZ, 1, 64'h4000000000000000);
    send_req(FN_NZ, 0, 64'h7FEFFFFFFFFFFFFF);
    send_req(FN_END, 0, ONE_BITS);
    // infinity times zero
    send_req(FN_NZ, 3, 64'd0);
    send_req(FN_END, 0, 64'h0000000000000001);
    // signed zeros, signaling nan, out-of-range column
    send_req(FN_NZ, 4095, ONE_BITS);
    send_req(FN_NZ, 2, 64'h7FF0000000000001);
    send_req(FN_NZ, 4096, ONE_BITS);
    send_req(FN_UNUSED, 8191, 64'hFFFFFFFFFFFFFFFF);
    send_req(FN_END, 8191, 64'h8000000000000000);
    // empty row
    send_req(FN_END, 0, 64'h800FFFFFFFFFFFFF);
  endtask

  // one-based columns: column zero is bad, column 4096 maps to the last entry
  task automatic test_index_base;
    write_base(1'b1);
    send_req(FN_NZ, 0, ONE_BITS);
    send_req(FN_NZ, 4096, 64'hC000000000000000);
    send_req(FN_NZ, 1, 64'h3FF8000000000000);
    send_req(FN_END, 0, 64'hBFF0000000000000);
    send_req(FN_NZ, 4097, ONE_BITS);
    send_req(FN_END, 0, 64'd0);
    write_base(1'b0);
  endtask

  // mostly well-formed rows with random content, some noise
  task automatic test_random_rows(input int target);
    int sel, n;
    logic [63:0] rnd;
    while (items_sent < target) begin
      idling_on = !(items_sent > 700 && items_sent < 1000);
      if (items_sent % 400 < 2 && items_sent > 100) write_base(1'($urandom_range(1)));
      if (items_sent > 1200 && items_sent < 1210) drain_rows();
      sel = $urandom_range(99);
      rnd = {$urandom, $urandom};
      if (sel < 4) begin
        send_req(FN_UNUSED, $urandom_range(8191), rnd);
      end else if (sel < 22) begin
        case ($urandom_range(19))
          0: send_req(FN_LOAD, STORE_DEPTH + $urandom_range(4095), rnd);
          1, 2: send_req(FN_LOAD, $urandom_range(4095), rand_double());
          default: send_req(FN_LOAD, $urandom_range(255), rand_double());
        endcase
      end else begin
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) send_req(FN_NZ, pick_column(), rand_double());
        send_req(FN_END, $urandom_range(8191), rand_double());
      end
    end
  endtask

  // response side stall
  always @(posedge clk) begin
    rsp_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  // compare each accepted response with the oldest predicted row sum
  always @(posedge clk) begin : check_rsp
    out_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (row_sums.size() == 0) begin
        report($sformatf("unexpected response %h", rsp.row_sum));
      end else begin
        want = row_sums.pop_front();
        if (rsp.row_sum !== want.row_sum)
          report($sformatf("row_sum %h, predicted %h", rsp.row_sum, want.row_sum));
        if (rsp.bad_index !== want.bad_index)
          report($sformatf("bad_index %b, predicted %b", rsp.bad_index, want.bad_index));
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_index_base();
    test_random_rows(1750);
    idling_on = 1'b1;
    drain_rows();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
